>>> hdl/lax_der_signature_parser_defines.svh
// ----------------------------------------------------------------------------
// Lax DER signature parser - assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LAX_DER_SIGNATURE_PARSER_DEFINES_SVH
`define LAX_DER_SIGNATURE_PARSER_DEFINES_SVH

// Same-cycle implication
`define LDSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LDSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ldsp_pkg.sv
// ----------------------------------------------------------------------------
// ldsp_pkg
// Types and constants shared by the lax DER signature parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldsp_pkg;

    // Stream limits
    localparam int MAX_STREAM_BYTES_DEF = 65535;
    localparam int MIN_SIG_BYTES        = 8;
    localparam int INT_MAX_BYTES        = 32;
    localparam int MAX_SIG_LEN_BYTES    = 4;

    // Encoding bytes
    localparam logic [7:0] SEQ_TAG   = 8'h30;
    localparam logic [7:0] INT_TAG   = 8'h02;
    localparam logic [7:0] HASH_ALL  = 8'h01;

    // Field widths
    localparam int LIMB_W   = 64;
    localparam int NUM_LIMB = 4;
    localparam int INT_W    = LIMB_W * NUM_LIMB;
    localparam int LEN_W    = 24;
    localparam int IDX_W    = 3;
    localparam int M_DATA_W = 72;

    // Record queue between parser and limb emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HDR,
        PH_SEQLEN,
        PH_SEQSKIP,
        PH_RMARK,
        PH_RLENHDR,
        PH_RLENB,
        PH_RDATA,
        PH_SMARK,
        PH_SLENHDR,
        PH_SLENB,
        PH_SDATA,
        PH_HASHT,
        PH_TRAIL
    } phase_t;

    // One parsed signature
    typedef struct packed {
        logic             ok;
        logic             hash_type;
        logic [INT_W-1:0] r_val;
        logic [INT_W-1:0] s_val;
    } sig_rec_t;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> hdl/ldsp_front.sv
// ----------------------------------------------------------------------------
// ldsp_front
// Byte parser: walks the DER phases one byte per cycle unless the queue is
// full, and pushes one record per signature into it on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldsp_front import ldsp_pkg::*; #(
    parameter int MAX_STREAM_BYTES = MAX_STREAM_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      byte_acc,
    input  logic [7:0] sig_byte,
    input  logic      final_byte,
    output logic      rec_push,
    output sig_rec_t  rec
);

    localparam int POS_W = $clog2(MAX_STREAM_BYTES + 1);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               err_reg, err_next;
    logic [6:0]         lbl_reg, lbl_next;
    logic [2:0]         slc_reg, slc_next;
    logic [LEN_W-1:0]   il_reg, il_next;
    logic [LEN_W-1:0]   ibl_reg, ibl_next;
    logic [INT_W-1:0]   r_reg, r_next;
    logic [INT_W-1:0]   s_reg, s_next;
    logic               hflag_reg, hflag_next;

    logic               is_s;
    logic [6:0]         lbl_dec;
    logic [2:0]         slc_inc;
    logic [LEN_W-1:0]   il_shift;
    logic [LEN_W-1:0]   ibl_dec;

    assign is_s     = (phase_reg == PH_SLENHDR) || (phase_reg == PH_SLENB) ||
                      (phase_reg == PH_SDATA);
    assign lbl_dec  = lbl_reg - 7'd1;
    assign slc_inc  = slc_reg + 3'd1;
    assign il_shift = {il_reg[LEN_W-9:0], sig_byte};
    assign ibl_dec  = ibl_reg - LEN_W'(1);

    // Next parse state for the accepted byte
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        lbl_next   = lbl_reg;
        slc_next   = slc_reg;
        il_next    = il_reg;
        ibl_next   = ibl_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        hflag_next = hflag_reg;
        if (byte_acc) begin
            if (!err_reg) begin
                case (phase_reg)
                    PH_HDR: begin
                        if (sig_byte != SEQ_TAG) err_next = 1'b1;
                        else phase_next = PH_SEQLEN;
                    end
                    PH_SEQLEN: begin
                        if (sig_byte[7] && (sig_byte[6:0] != 7'd0)) begin
                            lbl_next   = sig_byte[6:0];
                            phase_next = PH_SEQSKIP;
                        end else begin
                            phase_next = PH_RMARK;
                        end
                    end
                    PH_SEQSKIP: begin
                        lbl_next = lbl_dec;
                        if (lbl_dec == 7'd0) phase_next = PH_RMARK;
                    end
                    PH_RMARK, PH_SMARK: begin
                        if (sig_byte != INT_TAG) err_next = 1'b1;
                        else phase_next = (phase_reg == PH_SMARK) ? PH_SLENHDR
                                                                  : PH_RLENHDR;
                    end
                    PH_RLENHDR, PH_SLENHDR: begin
                        if (sig_byte[7]) begin
                            if (sig_byte[6:0] == 7'd0) begin
                                err_next = 1'b1;
                            end else begin
                                lbl_next   = sig_byte[6:0];
                                slc_next   = 3'd0;
                                il_next    = '0;
                                phase_next = is_s ? PH_SLENB : PH_RLENB;
                            end
                        end else if (sig_byte == 8'd0) begin
                            err_next = 1'b1;
                        end else begin
                            il_next    = LEN_W'(sig_byte);
                            ibl_next   = LEN_W'(sig_byte);
                            phase_next = is_s ? PH_SDATA : PH_RDATA;
                        end
                    end
                    PH_RLENB, PH_SLENB: begin
                        lbl_next = lbl_dec;
                        if (!((sig_byte == 8'd0) && (slc_reg == 3'd0))) begin
                            slc_next = slc_inc;
                            if (slc_inc >= 3'(MAX_SIG_LEN_BYTES)) err_next = 1'b1;
                            else il_next = il_shift;
                        end
                        if (!err_next && (lbl_dec == 7'd0)) begin
                            if (il_next == '0) begin
                                err_next = 1'b1;
                            end else begin
                                ibl_next   = il_next;
                                phase_next = is_s ? PH_SDATA : PH_RDATA;
                            end
                        end
                    end
                    PH_RDATA, PH_SDATA: begin
                        if ((ibl_reg > LEN_W'(INT_MAX_BYTES)) && (sig_byte != 8'd0)) begin
                            err_next = 1'b1;
                        end else begin
                            if (is_s) s_next = {s_reg[INT_W-9:0], sig_byte};
                            else      r_next = {r_reg[INT_W-9:0], sig_byte};
                            ibl_next = ibl_dec;
                            if (ibl_dec == '0) phase_next = is_s ? PH_HASHT : PH_SMARK;
                        end
                    end
                    PH_HASHT: begin
                        if (sig_byte == HASH_ALL) hflag_next = 1'b1;
                        phase_next = PH_TRAIL;
                    end
                    default: begin
                    end
                endcase
            end
            if (pos_reg < POS_W'(MAX_STREAM_BYTES)) pos_next = pos_reg + POS_W'(1);
        end
    end

    // Build the record for the final byte
    always_comb begin
        rec_push      = byte_acc && final_byte;
        rec.ok        = !err_next && (pos_next >= POS_W'(MIN_SIG_BYTES)) &&
                        ((phase_next == PH_HASHT) || (phase_next == PH_TRAIL));
        rec.hash_type = hflag_next;
        rec.r_val     = r_next;
        rec.s_val     = s_next;
    end

    // Hold parse state; clear it on reset and after each final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            phase_reg <= PH_HDR;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
            lbl_reg   <= '0;
            slc_reg   <= '0;
            il_reg    <= '0;
            ibl_reg   <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            hflag_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            lbl_reg   <= lbl_next;
            slc_reg   <= slc_next;
            il_reg    <= il_next;
            ibl_reg   <= ibl_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            hflag_reg <= hflag_next;
        end
    end

endmodule

>>> hdl/ldsp_queue.sv
// ----------------------------------------------------------------------------
// ldsp_queue
// Short record queue that decouples the byte parser from the limb emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldsp_queue import ldsp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  sig_rec_t push_rec,
    input  logic     pop,
    output sig_rec_t head_rec,
    output q_stat_t  stat
);

    sig_rec_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_rec   = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store records
    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_rec;
    end

endmodule

>>> hdl/ldsp_back.sv
// ----------------------------------------------------------------------------
// ldsp_back
// Limb emitter: walks the head record and sends eight limb words, or one
// invalid word, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lax_der_signature_parser_defines.svh"

module ldsp_back import ldsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  sig_rec_t            head_rec,
    input  q_stat_t             stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [IDX_W-1:0]    m_tuser,
    output logic                m_tlast
);

    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                load;
    logic [INT_W-1:0]    int_sel;
    logic [LIMB_W-1:0]   limb;
    logic                is_last;

    assign load    = !valid_reg || m_tready;
    assign int_sel = cnt_reg[IDX_W-1] ? head_rec.s_val : head_rec.r_val;
    assign limb    = int_sel[cnt_reg[IDX_W-2:0] * LIMB_W +: LIMB_W];
    assign is_last = !head_rec.ok || (cnt_reg == IDX_W'(2 * NUM_LIMB - 1));

    // Next output word and limb counter
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !stat.empty;
            if (!stat.empty) begin
                data_next = '0;
                if (head_rec.ok) begin
                    data_next[0]          = 1'b1;
                    data_next[LIMB_W:1]   = limb;
                    data_next[LIMB_W + 1] = head_rec.hash_type;
                end
                idx_next  = head_rec.ok ? cnt_reg : '0;
                last_next = is_last;
                pop       = is_last;
                cnt_next  = is_last ? '0 : cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = idx_reg;
    assign m_tlast  = last_reg;

    `LDSP_ASSERT_IMP(a_invalid_single, valid_reg && !data_reg[0], last_reg && (idx_reg == '0), "invalid word must be a single last word at index 0")
    `LDSP_ASSERT_IMP(a_cnt_has_rec, cnt_reg != '0, !stat.empty, "limb counter running with empty queue")
    `LDSP_ASSERT_NXT(a_cnt_wraps, load && !stat.empty && is_last, cnt_reg == '0, "limb counter did not restart after last word")

endmodule

>>> hdl/lax_der_signature_parser.sv
// With the output stage idle, the record is written to the record queue when the final
// byte is accepted, and its first word is then registered in the output stage.
// Throughput: one input byte per cycle while s_tready is high; each signature then drains
// 8 words (1 if invalid) from the output register at one per cycle while m_tready is high.
// Two parsed signatures can wait in the record queue; s_tready drops while it is full.
// Reset: synchronous on aresetn low; clears parse state, queue and output valid.
// ----------------------------------------------------------------------------
// lax_der_signature_parser
// Lax DER ECDSA signature parser: bytes in, r and s limbs out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lax_der_signature_parser import ldsp_pkg::*; #(
    parameter int MAX_STREAM_BYTES = MAX_STREAM_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] sig_byte
    input  logic                s_tlast,    // final_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // [0] sig_valid, [64:1] limb_value,
                                            // [65] hash_type, [71:66] zero
    output logic [IDX_W-1:0]    m_tuser,    // [2:0] limb_index
    output logic                m_tlast     // run_last
);

    logic     byte_acc;
    logic     rec_push;
    sig_rec_t rec;
    sig_rec_t head_rec;
    q_stat_t  stat;
    logic     pop;

    assign s_tready = !stat.full;
    assign byte_acc = s_tvalid && s_tready;

    ldsp_front #(
        .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_acc   (byte_acc),
        .sig_byte   (s_tdata),
        .final_byte (s_tlast),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    ldsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_rec (rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (stat)
    );

    ldsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
